// ===== sv/rntf_pkg.sv =====
// Shared types, constants and helper functions for the roman numeral text filter.
package rntf_pkg;

   localparam logic [7:0] CHAR_SPACE  = 8'd32;
   localparam logic [7:0] CHAR_NL     = 8'd10;
   localparam logic [7:0] CHAR_TAB    = 8'd9;
   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_COMMA  = 8'd44;
   localparam logic [7:0] CHAR_PERIOD = 8'd46;
   localparam logic [7:0] CHAR_ZERO   = 8'd48;
   localparam logic [7:0] CHAR_I      = 8'd73;
   localparam logic [7:0] CHAR_V      = 8'd86;
   localparam logic [7:0] CHAR_X      = 8'd88;
   localparam logic [7:0] CHAR_L      = 8'd76;
   localparam logic [7:0] CHAR_C      = 8'd67;
   localparam logic [7:0] CHAR_D      = 8'd68;
   localparam logic [7:0] CHAR_M      = 8'd77;

   localparam int SYM_W     = 11;
   localparam int TOTAL_W   = 17;
   localparam int CONV_BITS = 16;
   localparam int CNT_W     = 4;
   localparam int DIGITS    = 5;
   localparam int DIG_W     = 3;
   localparam int BCD_W     = 4 * DIGITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPACE,
      ST_CONV,
      ST_DIGITS,
      ST_RD,
      ST_CHARS,
      ST_TAIL
   } state_type;

   typedef enum logic [1:0] {
      CLS_WORD,
      CLS_SPACE,
      CLS_PUNCT,
      CLS_EOT
   } class_type;

   typedef enum logic [1:0] {
      SRC_SPACE,
      SRC_DIGIT,
      SRC_RAM,
      SRC_TAIL
   } src_type;

   typedef struct packed {
      logic    add_byte;
      logic    latch_item;
      logic    conv_load;
      logic    conv_step;
      logic    dig_advance;
      logic    idx_inc;
      logic    rd_en;
      logic    clear_word;
      logic    emit;
      src_type emit_sel;
      logic    emit_last;
   } cmd_type;

   typedef struct packed {
      class_type req_class;
      logic      word_empty;
      logic      all_roman;
      logic      has_tail;
      logic      out_free;
      logic      conv_done;
      logic      dig_last;
      logic      dig_lead_zero;
      logic      idx_last;
   } stat_type;

   function automatic logic [SYM_W-1:0] symbol_value(input logic [7:0] c);
      logic [SYM_W-1:0] v;
      case (c)
         CHAR_I:  v = SYM_W'(1);
         CHAR_V:  v = SYM_W'(5);
         CHAR_X:  v = SYM_W'(10);
         CHAR_L:  v = SYM_W'(50);
         CHAR_C:  v = SYM_W'(100);
         CHAR_D:  v = SYM_W'(500);
         CHAR_M:  v = SYM_W'(1000);
         default: v = '0;
      endcase
      return v;
   endfunction

   // Add three to every BCD digit of five or more, ahead of the next shift.
   function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
      logic [BCD_W-1:0] r;
      r = b;
      for (int i = 0; i < DIGITS; i++) begin
         if (b[4*i +: 4] >= 4'd5) begin
            r[4*i +: 4] = b[4*i +: 4] + 4'd3;
         end
      end
      return r;
   endfunction

endpackage

// ===== sv/rntf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rntf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rntf_ctrl.sv =====
// Controller state machine: accepts characters and sequences the flush of a word.
module rntf_ctrl
   import rntf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               case (stat.req_class)
                  CLS_WORD: begin
                     cmd.add_byte = 1'b1;
                  end
                  CLS_SPACE: begin
                     if (!stat.word_empty) begin
                        state_in = ST_SPACE;
                     end
                  end
                  default: begin
                     state_in = stat.word_empty ? ST_TAIL : ST_SPACE;
                  end
               endcase
            end
         end
         ST_SPACE: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = SRC_SPACE;
               cmd.conv_load = 1'b1;
               state_in      = stat.all_roman ? ST_CONV : ST_RD;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (stat.conv_done) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (stat.dig_lead_zero && !stat.dig_last) begin
               cmd.dig_advance = 1'b1;
            end else if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = SRC_DIGIT;
               cmd.emit_last = stat.dig_last && !stat.has_tail;
               if (stat.dig_last) begin
                  cmd.clear_word = 1'b1;
                  state_in       = stat.has_tail ? ST_TAIL : ST_IDLE;
               end else begin
                  cmd.dig_advance = 1'b1;
               end
            end
         end
         ST_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHARS;
         end
         ST_CHARS: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = SRC_RAM;
               cmd.emit_last = stat.idx_last && !stat.has_tail;
               if (stat.idx_last) begin
                  cmd.clear_word = 1'b1;
                  state_in       = stat.has_tail ? ST_TAIL : ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_RD;
               end
            end
         end
         ST_TAIL: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = SRC_TAIL;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output register must be free whenever a byte is pushed into it.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("byte pushed while output register is occupied");

   // A finished flush leaves the word empty for the next character.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_word |=> stat.word_empty)
      else $error("word not empty after flush");

   // Every RAM read is followed by the cycle that presents its data.
   a_rd_then_chars: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |=> state_ff == ST_CHARS)
      else $error("read data not consumed in the following cycle");

   // The closing byte goes out as soon as the output register has room.
   a_tail_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAIL && stat.out_free) |=> state_ff == ST_IDLE)
      else $error("tail byte not sent");

endmodule

// ===== sv/rntf_dp.sv =====
// Datapath: word store, roman value accumulation, binary to BCD conversion, output register.
module rntf_dp
   import rntf_pkg::*;
#(
   parameter int WORD_CHARS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_char,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run,
   input  cmd_type    cmd,
   output stat_type   stat
);

   localparam int LEN_W  = $clog2(WORD_CHARS + 1);
   localparam int ADDR_W = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;

   logic [LEN_W-1:0]          len_ff, len_in;
   logic                      roman_ff, roman_in;
   logic [SYM_W-1:0]          pending_ff, pending_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic [7:0]                tail_ff;
   logic                      has_tail_ff;
   logic [CONV_BITS-1:0]      bin_ff;
   logic [BCD_W-1:0]          bcd_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [DIG_W-1:0]          dig_idx_ff;
   logic                      started_ff;
   logic [ADDR_W-1:0]         idx_ff;
   logic                      rsp_valid_ff;
   logic [7:0]                rsp_char_ff;
   logic                      rsp_last_ff;

   class_type                 req_class;
   logic [SYM_W-1:0]          sym;
   logic                      store_wr;
   logic [7:0]                ram_rd_data;
   logic [3:0]                digit;
   logic signed [TOTAL_W-1:0] word_value;
   logic [7:0]                emit_char;
   logic                      out_free;

   always_comb begin
      if (req_end_of_text) begin
         req_class = CLS_EOT;
      end else if (req_in_char == CHAR_SPACE ||
                   (req_in_char >= CHAR_TAB && req_in_char <= CHAR_CR)) begin
         req_class = CLS_SPACE;
      end else if (req_in_char == CHAR_COMMA || req_in_char == CHAR_PERIOD) begin
         req_class = CLS_PUNCT;
      end else begin
         req_class = CLS_WORD;
      end
   end

   assign sym      = symbol_value(req_in_char);
   assign store_wr = cmd.add_byte && (len_ff < LEN_W'(WORD_CHARS));

   // Word state: a symbol's sign is decided only once the next symbol is seen.
   always_comb begin
      len_in     = len_ff;
      roman_in   = roman_ff;
      pending_in = pending_ff;
      total_in   = total_ff;
      if (cmd.clear_word) begin
         len_in     = '0;
         roman_in   = 1'b1;
         pending_in = '0;
         total_in   = '0;
      end else if (store_wr) begin
         if (sym == '0) begin
            roman_in = 1'b0;
         end else if (len_ff != '0) begin
            if (pending_ff < sym) begin
               total_in = total_ff - $signed({{(TOTAL_W-SYM_W){1'b0}}, pending_ff});
            end else begin
               total_in = total_ff + $signed({{(TOTAL_W-SYM_W){1'b0}}, pending_ff});
            end
         end
         pending_in = sym;
         len_in     = len_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         roman_ff    <= 1'b1;
         pending_ff  <= '0;
         total_ff    <= '0;
         has_tail_ff <= 1'b0;
      end else begin
         len_ff     <= len_in;
         roman_ff   <= roman_in;
         pending_ff <= pending_in;
         total_ff   <= total_in;
         if (cmd.latch_item) begin
            has_tail_ff <= (req_class != CLS_SPACE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         tail_ff <= req_end_of_text ? CHAR_NL : req_in_char;
      end
   end

   rntf_ram #(
      .WIDTH (8),
      .DEPTH (WORD_CHARS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (req_in_char),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign word_value = total_ff + $signed({{(TOTAL_W-SYM_W){1'b0}}, pending_ff});

   // Shift-and-add-three conversion, one binary bit per cycle, most significant first.
   always_ff @(posedge clock) begin
      if (cmd.conv_load) begin
         bin_ff <= word_value[CONV_BITS-1:0];
         bcd_ff <= '0;
      end else if (cmd.conv_step) begin
         {bcd_ff, bin_ff} <= {bcd_adjust(bcd_ff), bin_ff} << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         dig_idx_ff <= '0;
         started_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         if (cmd.conv_load) begin
            cnt_ff     <= '0;
            dig_idx_ff <= DIG_W'(DIGITS - 1);
            started_ff <= 1'b0;
            idx_ff     <= '0;
         end else begin
            if (cmd.conv_step) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
            if (cmd.dig_advance) begin
               dig_idx_ff <= dig_idx_ff - DIG_W'(1);
            end
            if (cmd.emit && cmd.emit_sel == SRC_DIGIT) begin
               started_ff <= 1'b1;
            end
            if (cmd.idx_inc) begin
               idx_ff <= idx_ff + ADDR_W'(1);
            end
         end
      end
   end

   assign digit = bcd_ff[{dig_idx_ff, 2'b00} +: 4];

   always_comb begin
      case (cmd.emit_sel)
         SRC_SPACE: emit_char = CHAR_SPACE;
         SRC_DIGIT: emit_char = CHAR_ZERO | {4'b0000, digit};
         SRC_RAM:   emit_char = ram_rd_data;
         SRC_TAIL:  emit_char = tail_ff;
         default:   emit_char = CHAR_SPACE;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_last_of_run = rsp_last_ff;

   assign stat.req_class     = req_class;
   assign stat.word_empty    = (len_ff == '0);
   assign stat.all_roman     = roman_ff;
   assign stat.has_tail      = has_tail_ff;
   assign stat.out_free      = out_free;
   assign stat.conv_done     = (cnt_ff == CNT_W'(CONV_BITS - 1));
   assign stat.dig_last      = (dig_idx_ff == '0);
   assign stat.dig_lead_zero = (digit == 4'd0) && !started_ff;
   assign stat.idx_last      = ((LEN_W'(idx_ff) + LEN_W'(1)) == len_ff);

endmodule

// ===== sv/roman_numeral_text_filter_core.sv =====
// Word bytes are accepted back to back; whitespace with no word is accepted and sends nothing.
// A separator after a word is accepted, then the leading space is sent, then for a roman word the
// value is converted and its digit positions (5) are stepped through, or otherwise each stored byte
// is read from RAM, then transferred. A comma, period or end of text then sends one more byte;
// output stalls hold the flush. Synchronous active-high reset clears the controller,
// word length, value and output register; the word store is not cleared.
module roman_numeral_text_filter_core
   import rntf_pkg::*;
#(
   parameter int WORD_CHARS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   cmd_type  cmd;
   stat_type stat;

   rntf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rntf_dp #(
      .WORD_CHARS (WORD_CHARS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_in_char     (req_in_char),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

// ===== verif/tb.sv =====
// Testbench for the roman numeral text filter core: stimulus, prediction and checking.
module tb;
   import rntf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_CHARS  = 32;
   localparam int RANDOM_ITEMS = 300;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
   } text_item_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_char = 8'd0;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last_of_run;

   text_item_type text_q[$];
   out_byte_type  expected_bytes[$];
   text_item_type next_item;
   out_byte_type  want;

   // Word state of the predicted filter.
   logic [7:0] word_bytes [WORD_CHARS];
   int         word_len = 0;
   bit         word_is_roman = 1'b1;
   int         last_symbol = 0;
   int         decided_sum = 0;

   logic       req_fire = 1'b0;
   int         items_accepted = 0;
   int         error_count = 0;
   bit         hold_off = 1'b0;
   int         burst_left = 0;
   int         gap_left = 0;
   int         rx_mode = 0;
   int         rx_mode_left = 0;
   int         directed_items = 0;

   logic [7:0] roman_letters [7] = '{CHAR_I, CHAR_V, CHAR_X, CHAR_L, CHAR_C, CHAR_D, CHAR_M};

   roman_numeral_text_filter_core #(
      .WORD_CHARS(WORD_CHARS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_char    (req_in_char),
      .req_end_of_text(req_end_of_text),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always #6 clock = ~clock;

   function automatic int roman_weight(input logic [7:0] c);
      case (c)
         CHAR_I:  return 1;
         CHAR_V:  return 5;
         CHAR_X:  return 10;
         CHAR_L:  return 50;
         CHAR_C:  return 100;
         CHAR_D:  return 500;
         CHAR_M:  return 1000;
         default: return 0;
      endcase
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic bit is_separator(input logic [7:0] c);
      return is_blank(c) || (c == CHAR_COMMA) || (c == CHAR_PERIOD);
   endfunction

   // Works out the bytes that one accepted text item causes and queues them.
   task automatic filter_char(input logic [7:0] c, input logic eot);
      logic [7:0] run_bytes[$];
      string      digits;
      int         value;
      int         wt;
      if (eot || is_separator(c)) begin
         if (word_len != 0) begin
            run_bytes.push_back(CHAR_SPACE);
            if (word_is_roman) begin
               value = decided_sum + last_symbol;
               digits = $sformatf("%0d", value);
               for (int i = 0; i < digits.len(); i++) begin
                  run_bytes.push_back(digits[i]);
               end
            end else begin
               for (int i = 0; i < word_len; i++) begin
                  run_bytes.push_back(word_bytes[i]);
               end
            end
            word_len = 0;
            word_is_roman = 1'b1;
            last_symbol = 0;
            decided_sum = 0;
         end
         if (eot) begin
            run_bytes.push_back(CHAR_NL);
         end else if (!is_blank(c)) begin
            run_bytes.push_back(c);
         end
      end else if (word_len < WORD_CHARS) begin
         // Bytes past the word capacity are dropped without any effect.
         word_bytes[word_len] = c;
         wt = roman_weight(c);
         if (wt == 0) begin
            word_is_roman = 1'b0;
         end else if (word_len != 0) begin
            if (last_symbol < wt) begin
               decided_sum -= last_symbol;
            end else begin
               decided_sum += last_symbol;
            end
         end
         last_symbol = wt;
         word_len++;
      end
      foreach (run_bytes[i]) begin
         expected_bytes.push_back('{ch: run_bytes[i], last: (i == run_bytes.size() - 1)});
      end
   endtask

   task automatic add_char(input logic [7:0] c);
      text_q.push_back('{ch: c, eot: 1'b0});
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i]);
      end
   endtask

   task automatic add_eot(input logic [7:0] c);
      text_q.push_back('{ch: c, eot: 1'b1});
   endtask

   task automatic add_roman_word(input int len, input bit only_m);
      for (int i = 0; i < len; i++) begin
         add_char(only_m ? CHAR_M : roman_letters[$urandom_range(0, 6)]);
      end
   endtask

   task automatic add_plain_word(input int len);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            b = roman_letters[$urandom_range(0, 6)];
         end else begin
            do begin
               b = 8'($urandom_range(0, 255));
            end while (is_separator(b));
         end
         add_char(b);
      end
   endtask

   task automatic add_separator();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 3) begin
         add_char(CHAR_SPACE);
      end else if (r <= 5) begin
         add_char(8'($urandom_range(9, 13)));
      end else if (r == 6) begin
         add_char(CHAR_COMMA);
      end else if (r == 7) begin
         add_char(CHAR_PERIOD);
      end else if (r == 8) begin
         add_eot(8'($urandom_range(0, 255)));
      end
      // Otherwise no separator, so the next word runs on into this one.
   endtask

   // Sender: items are offered in bursts of random length with random gaps, sometimes none, between them.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // Hold the offered item until it is taken.
      end else if (gap_left != 0 || text_q.size() == 0) begin
         req_valid <= 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end
      end else begin
         next_item = text_q.pop_front();
         req_valid <= 1'b1;
         req_in_char <= next_item.ch;
         req_end_of_text <= next_item.eot;
         if (burst_left > 0) begin
            burst_left--;
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end
      end
   end

   // Receiver: ready follows a mode that is redrawn at random intervals.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 100);
         end
         rx_mode_left--;
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Long receiver stall while the sender keeps going, so the core backs up.
   initial begin
      wait (items_accepted >= 60);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // Prediction on every input transfer, checking on every output transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            filter_char(req_in_char, req_end_of_text);
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected output transfer: out_char 8'h%02h last_of_run %0b",
                      rsp_out_char, rsp_last_of_run);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_char !== want.ch) begin
                  $error("out_char: expected 8'h%02h, actual 8'h%02h", want.ch, rsp_out_char);
                  error_count++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $error("last_of_run: expected %0b, actual %0b", want.last, rsp_last_of_run);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      int r;
      // Directed text: roman values with subtraction, plain words, lone punctuation,
      // whitespace with no word, odd bytes as word bytes, and end of text.
      add_text("XLIX");
      add_char(CHAR_TAB);
      add_text("Ab,");
      add_char(CHAR_PERIOD);
      add_char(CHAR_SPACE);
      add_char(8'h00);
      add_char(8'hFF);
      add_char(CHAR_CR);
      add_char(CHAR_I);
      add_char(CHAR_NL);
      add_char(CHAR_D);
      add_char(8'd11);
      add_char(8'd12);
      add_char(CHAR_C);
      add_eot(8'hA5);
      add_eot(CHAR_SPACE);
      add_text("MCMXCIV.");
      directed_items = text_q.size();

      while (text_q.size() < directed_items + RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            if ($urandom_range(0, 19) == 0) begin
               add_roman_word($urandom_range(30, 40), 1'($urandom_range(0, 1)));
            end else begin
               add_roman_word($urandom_range(1, 7), 1'b0);
            end
            add_separator();
         end else if (r < 70) begin
            if ($urandom_range(0, 19) == 0) begin
               add_plain_word($urandom_range(30, 40));
            end else begin
               add_plain_word($urandom_range(1, 8));
            end
            add_separator();
         end else if (r < 82) begin
            if ($urandom_range(0, 4) == 0) begin
               add_eot(8'($urandom_range(0, 255)));
            end else begin
               add_char(8'($urandom_range(0, 255)));
            end
         end else begin
            add_separator();
         end
      end
      add_eot(8'h00);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (text_q.size() == 0 && !req_valid);
      wait (expected_bytes.size() == 0);
      repeat (80) @(posedge clock);
      if (error_count == 0 && expected_bytes.size() == 0) begin
         $display("** roman_numeral_text_filter_core: PASSED **");
      end else begin
         $display("** roman_numeral_text_filter_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #24_000_000;
      $display("** roman_numeral_text_filter_core: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/rntf_pkg.sv
sv/rntf_ram.sv
sv/rntf_ctrl.sv
sv/rntf_dp.sv
sv/roman_numeral_text_filter_core.sv
verif/tb.sv
